// File: hw/rtl/lpd_pkg.sv
// Shared constants, register map and result type for the lidar packet decoder.
// No dependencies; imported by the channel interfaces and the top level.
package lpd_pkg;

    // Framing
    localparam int PACKETS_PER_REV  = 90;
    localparam int READS_PER_PACKET = 4;
    localparam int INDEX_SPAN       = 90;

    localparam logic [7:0] START_BYTE = 8'hFA;
    localparam logic [7:0] INDEX_BASE = 8'hA0;

    localparam logic [4:0] POS_INDEX      = 5'd1;
    localparam logic [4:0] POS_SPEED_LO   = 5'd2;
    localparam logic [4:0] POS_SPEED_HI   = 5'd3;
    localparam logic [4:0] POS_READS      = 5'd4;
    localparam logic [4:0] POS_READS_END  = 5'(4 + 4 * READS_PER_PACKET);
    localparam logic [4:0] POS_CHECK_LAST = 5'(4 + 4 * READS_PER_PACKET + 1);

    localparam logic [1:0] SUB_DIST_LO = 2'd0;
    localparam logic [1:0] SUB_DIST_HI = 2'd1;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int ANGLE_W  = 9;
    localparam int DIST_W   = 14;
    localparam int RPM_W    = 10;
    localparam int LEVEL_W  = 8;
    localparam int SUM_W    = 17;
    localparam int COUNT_W  = 7;
    localparam int OFFSET_W = 7;

    // Register map (word index = paddr[3:2])
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_TARGET_RPM = 2'd0;
    localparam logic [1:0] REG_RPM_BAND   = 2'd1;
    localparam logic [1:0] REG_PWM_START  = 2'd2;

    localparam logic [RPM_W-1:0]   TARGET_RPM_RST = 10'd240;
    localparam logic [7:0]         RPM_BAND_RST   = 8'd20;
    localparam logic [LEVEL_W-1:0] PWM_START_RST  = 8'd71;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

    // Reciprocal of PACKETS_PER_REV, exact for any 17-bit sum
    localparam int RECIP_SHIFT = 31;
    localparam int RECIP_W     = 25;
    localparam logic [RECIP_W-1:0] RECIP_MULT =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(PACKETS_PER_REV) - 64'd1)
                 / 64'(PACKETS_PER_REV));
    localparam int PROD_W = SUM_W + RECIP_W;

    localparam logic KIND_READ    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic                 result_kind;
        logic [ANGLE_W-1:0]   angle_deg;
        logic [DIST_W-1:0]    distance_mm;
        logic                 read_invalid;
        logic                 weak_signal;
        logic [RPM_W-1:0]     avg_rpm;
        logic [LEVEL_W-1:0]   drive_level;
        logic                 speed_in_band;
    } result_t;

endpackage

// File: hw/rtl/lpd_if.sv
// Valid/ready channel interfaces for the lidar packet decoder.
// Depends on lpd_pkg for field widths.
interface lpd_byte_if
    import lpd_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface lpd_result_if
    import lpd_pkg::*;
    ();
    logic                 valid;
    logic                 ready;
    logic                 result_kind;
    logic [ANGLE_W-1:0]   angle_deg;
    logic [DIST_W-1:0]    distance_mm;
    logic                 read_invalid;
    logic                 weak_signal;
    logic [RPM_W-1:0]     avg_rpm;
    logic [LEVEL_W-1:0]   drive_level;
    logic                 speed_in_band;

    modport source (output valid, output result_kind, output angle_deg, output distance_mm,
                    output read_invalid, output weak_signal, output avg_rpm,
                    output drive_level, output speed_in_band, input ready);
    modport sink   (input valid, input result_kind, input angle_deg, input distance_mm,
                    input read_invalid, input weak_signal, input avg_rpm,
                    input drive_level, input speed_in_band, output ready);
endinterface

// File: hw/rtl/lidar_packet_decode_speed_ctrl.sv
// Top level of the lidar packet decoder with motor speed control.
// Depends on lpd_pkg and the channel interfaces in lpd_if.sv.
//
// Usage:
//   byte_in    - one raw serial byte per beat. Bytes are ignored until the
//                0xFA start byte; then a 22-byte packet is framed by count.
//   result_out - one beat per distance read (four per packet) and one speed
//                summary beat after every 90th complete packet.
//   APB port   - target_rpm @0x0, rpm_band @0x4, pwm_start @0x8. Writing
//                pwm_start also reloads the drive level. Write only when idle.
// Output: a result is registered before result_out. Throughput: one byte
//   per cycle while the skid entry is empty. The decode of a byte is one
//   level of logic between the framing state and the output register.
//   The revolution average (sum / 90) comes from a reciprocal multiplier
//   that is registered and recomputed every cycle; the sum is final at
//   least 18 beats before the summary byte, so it is always settled.
// Stall: an output register plus a one-entry skid register. byte_in stays
//   ready while result_out is stalled until the skid entry fills.
// Reset: hunting for a start byte, counters and sum cleared, registers at
//   their defaults, drive level at pwm_start, no result pending.
module lidar_packet_decode_speed_ctrl
    import lpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    lpd_byte_if.sink          byte_in,
    lpd_result_if.source      result_out
);

    // Configuration
    logic [RPM_W-1:0]   target_rpm_reg;
    logic [7:0]         rpm_band_reg;
    logic [LEVEL_W-1:0] pwm_start_reg;

    // Framing and speed state
    logic                hunting_reg,   hunting_next;
    logic [4:0]          pos_reg,       pos_next;
    logic [OFFSET_W-1:0] offset_reg,    offset_next;   // packet index offset mod 90
    logic [7:0]          low_reg,       low_next;
    logic [SUM_W-1:0]    sum_reg,       sum_next;
    logic [COUNT_W-1:0]  count_reg,     count_next;
    logic [LEVEL_W-1:0]  pwm_reg,       pwm_next;
    logic [PROD_W-1:0]   prod_reg;

    // Output side
    result_t out_reg,  out_next;
    result_t skid_reg, skid_next;
    logic    out_valid_reg,  out_valid_next;
    logic    skid_valid_reg, skid_valid_next;

    logic    cfg_wr;
    logic    accept;
    logic    res_valid;
    result_t res;

    logic [7:0]         b;
    logic [7:0]         idx_diff;
    logic [4:0]         rel;
    logic [RPM_W-1:0]   avg;
    logic [RPM_W:0]     upper;
    logic [RPM_W:0]     avg_plus_band;
    logic [COUNT_W-1:0] count_inc;

    // ---------------- APB ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_TARGET_RPM: prdata = 32'(target_rpm_reg);
            REG_RPM_BAND:   prdata = 32'(rpm_band_reg);
            REG_PWM_START:  prdata = 32'(pwm_start_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_rpm_reg <= TARGET_RPM_RST;
            rpm_band_reg   <= RPM_BAND_RST;
            pwm_start_reg  <= PWM_START_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[3:2] == REG_TARGET_RPM)
                target_rpm_reg <= pwdata[RPM_W-1:0];
            if (paddr[3:2] == REG_RPM_BAND)
                rpm_band_reg <= pwdata[7:0];
            if (paddr[3:2] == REG_PWM_START)
                pwm_start_reg <= pwdata[LEVEL_W-1:0];
        end
    end

    // ---------------- byte decode ----------------
    assign byte_in.ready = !skid_valid_reg;
    assign accept        = byte_in.valid && byte_in.ready;
    assign b             = byte_in.data_byte;

    assign idx_diff      = b - INDEX_BASE;
    assign rel           = pos_reg - POS_READS;
    assign avg           = prod_reg[RECIP_SHIFT +: RPM_W];
    assign upper         = {1'b0, target_rpm_reg} + (RPM_W+1)'(rpm_band_reg);
    assign avg_plus_band = {1'b0, avg} + (RPM_W+1)'(rpm_band_reg);
    assign count_inc     = count_reg + 1'b1;

    always_comb
    begin
        hunting_next = hunting_reg;
        pos_next     = pos_reg;
        offset_next  = offset_reg;
        low_next     = low_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        pwm_next     = pwm_reg;
        res_valid    = 1'b0;
        res          = '0;

        if (accept)
        begin
            if (hunting_reg)
            begin
                if (b == START_BYTE)
                begin
                    hunting_next = 1'b0;
                    pos_next     = POS_INDEX;
                end
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                priority if (pos_reg == POS_INDEX)
                begin
                    // offset wraps in 8 bits, then reduce mod 90 (at most two steps)
                    if (idx_diff >= 8'(2 * INDEX_SPAN))
                        offset_next = OFFSET_W'(idx_diff - 8'(2 * INDEX_SPAN));
                    else if (idx_diff >= 8'(INDEX_SPAN))
                        offset_next = OFFSET_W'(idx_diff - 8'(INDEX_SPAN));
                    else
                        offset_next = OFFSET_W'(idx_diff);
                end
                else if (pos_reg == POS_SPEED_LO)
                begin
                    low_next = b;
                end
                else if (pos_reg == POS_SPEED_HI)
                begin
                    // speed / 64 = {hi, lo[7:6]}
                    sum_next = sum_reg + SUM_W'({b, low_reg[7:6]});
                end
                else if (pos_reg >= POS_READS && pos_reg < POS_READS_END)
                begin
                    if (rel[1:0] == SUB_DIST_LO)
                    begin
                        low_next = b;
                    end
                    else if (rel[1:0] == SUB_DIST_HI)
                    begin
                        res_valid         = 1'b1;
                        res.result_kind   = KIND_READ;
                        res.angle_deg     = {offset_reg, rel[3:2]};
                        res.distance_mm   = b[7] ? '0 : {b[5:0], low_reg};
                        res.read_invalid  = b[7];
                        res.weak_signal   = b[6];
                        res.drive_level   = pwm_reg;
                    end
                end
                else if (pos_reg >= POS_CHECK_LAST)
                begin
                    hunting_next = 1'b1;
                    pos_next     = '0;
                    count_next   = count_inc;
                    if (count_inc >= COUNT_W'(PACKETS_PER_REV))
                    begin
                        res_valid = 1'b1;
                        res.result_kind   = KIND_SUMMARY;
                        res.avg_rpm       = avg;
                        res.speed_in_band = 1'b0;
                        priority if ({1'b0, avg} > upper)
                        begin
                            if (pwm_reg != '0)
                                pwm_next = pwm_reg - 1'b1;
                        end
                        else if (avg_plus_band < {1'b0, target_rpm_reg})
                        begin
                            if (pwm_reg != LEVEL_MAX)
                                pwm_next = pwm_reg + 1'b1;
                        end
                        else
                        begin
                            res.speed_in_band = 1'b1;
                        end
                        res.drive_level = pwm_next;
                        sum_next        = '0;
                        count_next      = '0;
                    end
                end
                else
                begin
                    // first checksum byte: skipped
                end
            end
        end

        // new start level takes effect at once
        if (cfg_wr && paddr[3:2] == REG_PWM_START)
            pwm_next = pwdata[LEVEL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunting_reg <= 1'b1;
            pos_reg     <= '0;
            offset_reg  <= '0;
            low_reg     <= '0;
            sum_reg     <= '0;
            count_reg   <= '0;
            pwm_reg     <= PWM_START_RST;
        end
        else
        begin
            hunting_reg <= hunting_next;
            pos_reg     <= pos_next;
            offset_reg  <= offset_next;
            low_reg     <= low_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            pwm_reg     <= pwm_next;
        end
    end

    // free-running reciprocal multiply: sum * ceil(2^31 / 90)
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(sum_reg) * PROD_W'(RECIP_MULT);
    end

    // ---------------- output register + skid ----------------
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;

        if (skid_valid_reg)
        begin
            if (result_out.ready)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || result_out.ready)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.result_kind   = out_reg.result_kind;
    assign result_out.angle_deg     = out_reg.angle_deg;
    assign result_out.distance_mm   = out_reg.distance_mm;
    assign result_out.read_invalid  = out_reg.read_invalid;
    assign result_out.weak_signal   = out_reg.weak_signal;
    assign result_out.avg_rpm       = out_reg.avg_rpm;
    assign result_out.drive_level   = out_reg.drive_level;
    assign result_out.speed_in_band = out_reg.speed_in_band;

endmodule

// File: dv/lidar_packet_decode_speed_ctrl_tb.sv
// Self-checking testbench for the lidar packet decoder with motor speed control.
// Needs lpd_pkg, the channel interfaces of lpd_if.sv and the top level RTL.
// A directed packet table comes first, then random byte streams and full revolutions.
module lidar_packet_decode_speed_ctrl_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpd_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 4;
    localparam int RANDOM_BYTES   = 550;   // decoded bytes in the random stream part
    localparam int SETTLE_CYCLES  = 4;     // pause after the last beat before a register write
    localparam int DRAIN_CYCLES   = 8;     // watch for stray beats once nothing is expected
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake or APB access
    localparam int FIXED_PHASES   = 10;
    localparam int RANDOM_PHASES  = 4;

    localparam result_t NO_BEAT = '0;

    typedef struct {
        logic [7:0] data;
        bit         has_typed;   // expected beat typed into the table
        result_t    typed;
    } stim_row_t;

    typedef struct {
        int target;
        int band;
        int start;
        int rpm;      // whole rpm at the centre of the phase's packets
        int spread;   // random deviation around rpm, per packet
        int revs;     // revolution summaries to collect
    } speed_phase_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    lpd_byte_if   byte_in ();
    lpd_result_if result_out ();

    lidar_packet_decode_speed_ctrl uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .byte_in    (byte_in),
        .result_out (result_out)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // Decoder model state. Mirrors the block's framing state, the running
    // speed sum and the drive level, plus our copy of the three registers.
    // ------------------------------------------------------------------
    bit          hunting;
    logic [4:0]  frame_pos;
    logic [7:0]  frame_index;
    logic [7:0]  held_low;
    logic [16:0] rev_speed_sum;
    logic [6:0]  rev_packets;
    logic [7:0]  drive_now;
    logic [9:0]  cfg_target;
    logic [7:0]  cfg_band;
    logic [7:0]  cfg_pwm_start;

    result_t     pending_beats[$];   // beats the block still owes us, oldest first

    // Coverage-ish tallies for the closing summary
    int bytes_decoded;
    int reads_seen;
    int invalid_seen;
    int weak_seen;
    int summaries_seen;
    int inband_seen;
    int steps_up;
    int steps_down;
    int held_at_limit;

    int mismatches;
    int idle_cycles;
    int src_mode;
    int sink_mode;
    int sink_stall;
    int seq_index;

    stim_row_t    directed_rows[24];
    speed_phase_t phases[FIXED_PHASES];

    // Gap length in cycles; mode 0 never idles, mode 2 idles hardest.
    // Mostly short gaps with the odd long one.
    function automatic int pick_gap(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0)
            return 0;
        if (mode == 1)
        begin
            if (r < 75) return 0;
            if (r < 95) return $urandom_range(1, 3);
            if (r < 99) return $urandom_range(4, 12);
            return $urandom_range(20, 40);
        end
        if (r < 40) return 0;
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic int pick_mode();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return 0;
        if (r < 7) return 1;
        return 2;
    endfunction

    function automatic result_t read_beat(input int angle, input logic [13:0] dist_mm,
                                          input logic inv, input logic weak_flag);
        result_t r;
        r              = '0;
        r.result_kind  = KIND_READ;
        r.angle_deg    = ANGLE_W'(angle);
        r.distance_mm  = dist_mm;
        r.read_invalid = inv;
        r.weak_signal  = weak_flag;
        r.drive_level  = PWM_START_RST;
        return r;
    endfunction

    // Advance the model by one accepted byte. Returns 1 when the byte makes
    // the block emit a beat, which is then left in 'res'.
    function automatic bit decode_byte(input logic [7:0] b, output result_t res);
        logic [4:0]  rel;
        logic [7:0]  idx_off;
        logic [15:0] speed;
        int          offset;
        int          avg;
        bit          produced;
        res      = '0;
        produced = 1'b0;
        if (hunting)
        begin
            // anything but the start byte is dropped on the floor
            if (b == START_BYTE)
            begin
                hunting   = 1'b0;
                frame_pos = POS_INDEX;
                bytes_decoded++;
            end
            return 1'b0;
        end
        bytes_decoded++;
        if (frame_pos == POS_INDEX)
            frame_index = b;
        else if (frame_pos == POS_SPEED_LO)
            held_low = b;
        else if (frame_pos == POS_SPEED_HI)
        begin
            speed         = {b, held_low};
            rev_speed_sum = rev_speed_sum + 17'(speed[15:6]);
        end
        else if (frame_pos >= POS_READS && frame_pos < POS_READS_END)
        begin
            rel = frame_pos - POS_READS;
            if (rel[1:0] == SUB_DIST_LO)
                held_low = b;
            else if (rel[1:0] == SUB_DIST_HI)
            begin
                // out-of-range indexes wrap in 8 bits, then fold into 0..89
                idx_off          = frame_index - INDEX_BASE;
                offset           = int'(idx_off) % INDEX_SPAN;
                res.result_kind  = KIND_READ;
                res.angle_deg    = ANGLE_W'(offset * READS_PER_PACKET + int'(rel[3:2]));
                res.distance_mm  = b[7] ? '0 : {b[5:0], held_low};
                res.read_invalid = b[7];
                res.weak_signal  = b[6];
                res.drive_level  = drive_now;
                produced         = 1'b1;
                reads_seen++;
                if (b[7]) invalid_seen++;
                if (b[6]) weak_seen++;
            end
        end
        else if (frame_pos >= POS_CHECK_LAST)
        begin
            rev_packets = rev_packets + 1'b1;
            if (rev_packets >= PACKETS_PER_REV)
            begin
                // the average is a 10-bit field, compared after trimming
                avg             = (int'(rev_speed_sum) / PACKETS_PER_REV) % 1024;
                res.result_kind = KIND_SUMMARY;
                res.avg_rpm     = RPM_W'(avg);
                // compared as plain ints, so a target below the band cannot wrap
                if (avg > int'(cfg_target) + int'(cfg_band))
                begin
                    if (drive_now != '0)
                    begin
                        drive_now = drive_now - 1'b1;
                        steps_down++;
                    end
                    else
                        held_at_limit++;
                end
                else if (avg + int'(cfg_band) < int'(cfg_target))
                begin
                    if (drive_now != LEVEL_MAX)
                    begin
                        drive_now = drive_now + 1'b1;
                        steps_up++;
                    end
                    else
                        held_at_limit++;
                end
                else
                begin
                    res.speed_in_band = 1'b1;
                    inband_seen++;
                end
                res.drive_level = drive_now;
                rev_speed_sum   = '0;
                rev_packets     = '0;
                produced        = 1'b1;
                summaries_seen++;
            end
            hunting   = 1'b1;
            frame_pos = '0;
            return produced;
        end
        frame_pos = frame_pos + 1'b1;
        return produced;
    endfunction

    // One byte beat on byte_in, preceded by a random gap. The expectation is
    // queued at the edge where the beat is taken.
    task automatic send_byte(input logic [7:0] b, input bit use_typed = 1'b0,
                             input result_t typed = '0);
        int      gap;
        bit      got;
        result_t pred;
        gap = pick_gap(src_mode);
        if (gap > 0)
        begin
            @(negedge clk);
            byte_in.valid     = 1'b0;
            byte_in.data_byte = 8'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        byte_in.valid     = 1'b1;
        byte_in.data_byte = b;
        @(posedge clk);
        while (byte_in.ready !== 1'b1) @(posedge clk);
        got = decode_byte(b, pred);
        if (use_typed)
            pending_beats.push_back(typed);
        else if (got)
            pending_beats.push_back(pred);
    endtask

    // Well-formed 22-byte packet with random reads; about one read in eight
    // comes back invalid.
    task automatic send_packet(input logic [7:0] index, input logic [15:0] speed);
        logic [7:0] hi;
        send_byte(START_BYTE);
        send_byte(index);
        send_byte(speed[7:0]);
        send_byte(speed[15:8]);
        for (int r = 0; r < READS_PER_PACKET; r++)
        begin
            hi = 8'($urandom);
            if ($urandom_range(0, 3) != 0)
                hi[7] = 1'b0;
            send_byte(8'($urandom));
            send_byte(hi);
            send_byte(8'($urandom));   // signal strength, not decoded
            send_byte(8'($urandom));
        end
        send_byte(8'($urandom));       // checksum, skipped by the block
        send_byte(8'($urandom));
    endtask

    // Drop valid and wait until every owed beat has come out, plus a margin.
    task automatic settle();
        @(negedge clk);
        byte_in.valid = 1'b0;
        while (pending_beats.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_reg(input logic [1:0] idx, input logic [31:0] want);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (pready !== 1'b1) @(posedge clk);
        if (prdata !== want)
        begin
            $display("%0t: register %0d read back, expected 0x%0h actual 0x%0h",
                     $time, idx, want, prdata);
            mismatches++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] readback;
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (pready !== 1'b1) @(posedge clk);
        case (idx)
            REG_TARGET_RPM:
            begin
                cfg_target = value[9:0];
                readback   = 32'(cfg_target);
            end
            REG_RPM_BAND:
            begin
                cfg_band = value[7:0];
                readback = 32'(cfg_band);
            end
            default:
            begin
                // a new start level reloads the drive level straight away
                cfg_pwm_start = value[7:0];
                drive_now     = value[7:0];
                readback      = 32'(cfg_pwm_start);
            end
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        check_reg(idx, readback);
    endtask

    task automatic apply_settings(input speed_phase_t ph);
        settle();
        write_reg(REG_TARGET_RPM, 32'(ph.target));
        write_reg(REG_RPM_BAND, 32'(ph.band));
        write_reg(REG_PWM_START, 32'(ph.start));
    endtask

    // Stream packets until the given number of revolution summaries is due.
    // The first revolution of a phase may mix in packets of the previous one,
    // so phases that aim at an exact average run at least two.
    task automatic run_revolutions(input speed_phase_t ph);
        int         goal;
        int         rpm;
        logic [7:0] index;
        goal      = summaries_seen + ph.revs;
        src_mode  = pick_mode();
        sink_mode = pick_mode();
        while (summaries_seen < goal)
        begin
            if ($urandom_range(0, 29) == 0)
            begin
                src_mode  = pick_mode();
                sink_mode = pick_mode();
            end
            // line noise between packets, never a start byte
            if ($urandom_range(0, 9) == 0)
                send_byte(8'($urandom_range(0, 8'hF9)));
            rpm = ph.rpm + int'($urandom_range(0, 2 * ph.spread)) - ph.spread;
            if (rpm < 0)
                rpm = 0;
            if (rpm > 1023)
                rpm = 1023;
            if ($urandom_range(0, 19) == 0)
                index = 8'($urandom);
            else
                index = 8'(INDEX_BASE + (seq_index % INDEX_SPAN));
            seq_index++;
            send_packet(index, {RPM_W'(rpm), 6'($urandom)});
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure. After each cycle with ready high
    // a stall of random length may follow.
    // ------------------------------------------------------------------
    initial
    begin
        result_out.ready = 1'b0;
        sink_stall       = 0;
        forever
        begin
            @(negedge clk);
            if (sink_stall > 0)
            begin
                result_out.ready = 1'b0;
                sink_stall--;
            end
            else
            begin
                result_out.ready = 1'b1;
                sink_stall       = pick_gap(sink_mode);
            end
        end
    end

    // Compare one field and report every difference.
    task automatic note_field(input string name, input logic [31:0] want,
                              input logic [31:0] got, inout bit bad);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            bad = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Result monitor: every beat taken on result_out is checked against the
    // oldest expectation, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        result_t want;
        bit      bad;
        if (rst_n === 1'b1 && result_out.valid === 1'b1 && result_out.ready === 1'b1)
        begin
            if (pending_beats.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, kind %0d angle %0d avg %0d",
                         $time, result_out.result_kind, result_out.angle_deg,
                         result_out.avg_rpm);
                mismatches++;
            end
            else
            begin
                want = pending_beats.pop_front();
                bad  = 1'b0;
                note_field("result_kind", 32'(want.result_kind),
                           32'(result_out.result_kind), bad);
                note_field("angle_deg", 32'(want.angle_deg), 32'(result_out.angle_deg), bad);
                note_field("distance_mm", 32'(want.distance_mm),
                           32'(result_out.distance_mm), bad);
                note_field("read_invalid", 32'(want.read_invalid),
                           32'(result_out.read_invalid), bad);
                note_field("weak_signal", 32'(want.weak_signal),
                           32'(result_out.weak_signal), bad);
                note_field("avg_rpm", 32'(want.avg_rpm), 32'(result_out.avg_rpm), bad);
                note_field("drive_level", 32'(want.drive_level),
                           32'(result_out.drive_level), bad);
                note_field("speed_in_band", 32'(want.speed_in_band),
                           32'(result_out.speed_in_band), bad);
                if (bad)
                    mismatches++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: a run that stops moving is a failure.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((byte_in.valid === 1'b1 && byte_in.ready === 1'b1) ||
            (result_out.valid === 1'b1 && result_out.ready === 1'b1) ||
            (psel === 1'b1 && penable === 1'b1))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles, %0d results still owed",
                         $time, idle_cycles, pending_beats.size());
                $display("lidar_packet_decode_speed_ctrl_tb: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        speed_phase_t ph;
        int           start_count;
        int           last_pick;
        int           r;

        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        byte_in.valid     = 1'b0;
        byte_in.data_byte = '0;
        rst_n             = 1'b0;
        idle_cycles       = 0;
        mismatches        = 0;
        seq_index         = 0;
        src_mode          = 1;
        sink_mode         = 1;

        // model comes up like the block: hunting, everything cleared
        hunting       = 1'b1;
        frame_pos     = '0;
        frame_index   = '0;
        held_low      = '0;
        rev_speed_sum = '0;
        rev_packets   = '0;
        cfg_target    = TARGET_RPM_RST;
        cfg_band      = RPM_BAND_RST;
        cfg_pwm_start = PWM_START_RST;
        drive_now     = PWM_START_RST;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Register defaults straight out of reset
        check_reg(REG_TARGET_RPM, 32'd240);
        check_reg(REG_RPM_BAND, 32'd20);
        check_reg(REG_PWM_START, 32'd71);

        // Directed packet: noise before the start byte, the last valid index
        // (angles 356..359), speed at the default target, then reads with a
        // full-scale distance, invalid plus weak, weak alone, and start bytes
        // sitting in the data and the checksum.
        directed_rows = '{
            '{8'h00, 1'b0, NO_BEAT},      // ignored while hunting
            '{8'hFF, 1'b0, NO_BEAT},      // ignored while hunting
            '{8'hFA, 1'b0, NO_BEAT},      // start
            '{8'hF9, 1'b0, NO_BEAT},      // index, offset 89
            '{8'h00, 1'b0, NO_BEAT},      // speed 0x3C00 = 240 rpm
            '{8'h3C, 1'b0, NO_BEAT},
            '{8'hFF, 1'b0, NO_BEAT},
            '{8'h3F, 1'b1, read_beat(356, 14'h3FFF, 1'b0, 1'b0)},
            '{8'h12, 1'b0, NO_BEAT},
            '{8'h34, 1'b0, NO_BEAT},
            '{8'hFF, 1'b0, NO_BEAT},
            '{8'hFF, 1'b1, read_beat(357, 14'd0, 1'b1, 1'b1)},
            '{8'h00, 1'b0, NO_BEAT},
            '{8'h00, 1'b0, NO_BEAT},
            '{8'h00, 1'b0, NO_BEAT},
            '{8'h40, 1'b1, read_beat(358, 14'd0, 1'b0, 1'b1)},
            '{8'hFA, 1'b0, NO_BEAT},
            '{8'hFA, 1'b0, NO_BEAT},
            '{8'hFA, 1'b0, NO_BEAT},      // start byte as distance data
            '{8'h00, 1'b1, read_beat(359, 14'd250, 1'b0, 1'b0)},
            '{8'hFF, 1'b0, NO_BEAT},
            '{8'h00, 1'b0, NO_BEAT},
            '{8'hFA, 1'b0, NO_BEAT},      // checksum
            '{8'hFA, 1'b0, NO_BEAT}
        };
        foreach (directed_rows[i])
            send_byte(directed_rows[i].data, directed_rows[i].has_typed, directed_rows[i].typed);

        // Random stream at the defaults: mostly packets with random content and
        // any index, the rest noise bursts and frames packed with start bytes.
        start_count = bytes_decoded;
        last_pick   = bytes_decoded;
        while (bytes_decoded - start_count < RANDOM_BYTES)
        begin
            if (bytes_decoded - last_pick >= 60)
            begin
                src_mode  = pick_mode();
                sink_mode = pick_mode();
                last_pick = bytes_decoded;
            end
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_packet(8'(INDEX_BASE + $urandom_range(0, INDEX_SPAN - 1)),
                                16'($urandom));
                else
                    send_packet(8'($urandom), 16'($urandom));
            end
            else if (r < 85)
            begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end
            else
            begin
                send_byte(START_BYTE);
                repeat (21) send_byte($urandom_range(0, 1) ? START_BYTE : 8'($urandom));
            end
        end

        // Full revolutions under fixed settings: both edges of the band, steps
        // both ways, saturation at 0 and 255, a target below the band and the
        // register extremes.
        phases = '{
            '{240,  20,  71,  260, 0, 2},
            '{240,  20,  71,  261, 0, 2},
            '{240,  20,  71,  220, 0, 2},
            '{240,  20,  71,  219, 0, 2},
            '{0,     0,   1,    5, 0, 3},
            '{1023,  0, 254, 1022, 0, 3},
            '{1023,  0, 255, 1023, 0, 2},
            '{5,    20, 128,    0, 0, 2},
            '{1023, 255,  0,  767, 0, 2},
            '{1023, 255,  0,  768, 0, 2}
        };
        foreach (phases[p])
        begin
            apply_settings(phases[p]);
            run_revolutions(phases[p]);
        end

        // Random settings, speeds scattered around the band edges
        repeat (RANDOM_PHASES)
        begin
            ph.target = $urandom_range(0, 1023);
            ph.band   = $urandom_range(0, 255);
            ph.start  = $urandom_range(0, 255);
            ph.rpm    = ph.target + int'($urandom_range(0, 2 * ph.band + 60)) - ph.band - 30;
            ph.spread = $urandom_range(0, 40);
            ph.revs   = 2;
            apply_settings(ph);
            run_revolutions(ph);
        end

        // Let the last beats drain, then watch a little longer for strays
        @(negedge clk);
        byte_in.valid = 1'b0;
        while (pending_beats.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d decoded bytes, %0d distance reads (%0d invalid, %0d weak)",
                 bytes_decoded, reads_seen, invalid_seen, weak_seen);
        $display("and %0d revolutions: %0d in band, %0d steps up, %0d down, %0d held at a limit",
                 summaries_seen, inband_seen, steps_up, steps_down, held_at_limit);
        if (mismatches == 0 && pending_beats.size() == 0)
            $display("lidar_packet_decode_speed_ctrl_tb: PASS");
        else
            $display("lidar_packet_decode_speed_ctrl_tb: FAIL");
        $finish;
    end

endmodule

// File: lidar_packet_decode_speed_ctrl.f
hw/rtl/lpd_pkg.sv
hw/rtl/lpd_if.sv
hw/rtl/lidar_packet_decode_speed_ctrl.sv
dv/lidar_packet_decode_speed_ctrl_tb.sv
